>>> hdl/tdp_pkg.sv
// Shared constants, types and state encodings for the trial division prime test.
package tdp_pkg;

  localparam int VALUE_WIDTH = 32;
  localparam int DIV_WIDTH = VALUE_WIDTH / 2 + 1;
  localparam int SQUARE_WIDTH = 2 * DIV_WIDTH;
  localparam int IDX_WIDTH = $clog2(VALUE_WIDTH);
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_WIDTH = $clog2(QUEUE_DEPTH);
  localparam int QCNT_WIDTH = $clog2(QUEUE_DEPTH + 1);

  localparam logic [DIV_WIDTH-1:0] FIRST_DIVISOR = DIV_WIDTH'(2);

  typedef enum logic [1:0] {
    CLS_NOT_PRIME,
    CLS_PRIME,
    CLS_TEST
  } class_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_BOUND,
    ST_DIVIDE,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [VALUE_WIDTH-1:0] value;
    logic                   last;
    class_t                 cls;
  } item_t;

endpackage

>>> hdl/tdp_if.sv
// Request and result channel interfaces of the trial division prime test.
interface tdp_req_if;
  logic                            valid;
  logic                            ready;
  logic [tdp_pkg::VALUE_WIDTH-1:0] candidate;
  logic                            last_in_range;

  modport source (output valid, output candidate, output last_in_range, input ready);
  modport sink (input valid, input candidate, input last_in_range, output ready);
endinterface

interface tdp_res_if;
  logic                            valid;
  logic                            ready;
  logic [tdp_pkg::VALUE_WIDTH-1:0] tested_value;
  logic                            is_prime;
  logic                            range_done;

  modport source (output valid, output tested_value, output is_prime, output range_done,
                  input ready);
  modport sink (input valid, input tested_value, input is_prime, input range_done,
                output ready);
endinterface

>>> hdl/tdp_front.sv
// Front stage: accepts requests and classifies each candidate before it is queued.
module tdp_front (
  input  logic           clk,
  input  logic           rst,
  tdp_req_if.sink        req,
  output tdp_pkg::item_t item,
  output logic           item_valid,
  input  logic           item_ready
);
  import tdp_pkg::*;

  class_t cls;

  always_comb begin
    if (req.candidate <= VALUE_WIDTH'(1)) begin
      cls = CLS_NOT_PRIME;
    end else if (req.candidate <= VALUE_WIDTH'(3)) begin
      cls = CLS_PRIME;
    end else if (!req.candidate[0]) begin
      cls = CLS_NOT_PRIME;
    end else begin
      cls = CLS_TEST;
    end
  end

  assign req.ready = !item_valid || item_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (req.ready) begin
      item_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      item.value <= req.candidate;
      item.last  <= req.last_in_range;
      item.cls   <= cls;
    end
  end

endmodule

>>> hdl/tdp_queue.sv
// Short queue between the front stage and the divider engine.
module tdp_queue (
  input  logic           clk,
  input  logic           rst,
  input  tdp_pkg::item_t push_item,
  input  logic           push_valid,
  output logic           push_ready,
  output tdp_pkg::item_t pop_item,
  output logic           pop_valid,
  input  logic           pop_ready
);
  import tdp_pkg::*;

  item_t                 mem [QUEUE_DEPTH];
  logic [QPTR_WIDTH-1:0] wr_ptr;
  logic [QPTR_WIDTH-1:0] rd_ptr;
  logic [QCNT_WIDTH-1:0] count;
  logic                  push;
  logic                  pop;

  assign push_ready = count != QCNT_WIDTH'(QUEUE_DEPTH);
  assign pop_valid  = count != '0;
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_item   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

endmodule

>>> hdl/tdp_back.sv
// Divider engine: tries each divisor with a bit-serial remainder and holds the result.
module tdp_back (
  input  logic           clk,
  input  logic           rst,
  input  tdp_pkg::item_t item,
  input  logic           item_valid,
  output logic           item_ready,
  tdp_res_if.source      res
);
  import tdp_pkg::*;

  state_t                  state;
  state_t                  state_next;
  logic [VALUE_WIDTH-1:0]  value;
  logic                    last;
  logic                    prime;
  logic [DIV_WIDTH-1:0]    divisor;
  logic [SQUARE_WIDTH-1:0] square;
  logic [DIV_WIDTH-1:0]    rem;
  logic [DIV_WIDTH-1:0]    rem_next;
  logic [DIV_WIDTH:0]      rem_shift;
  logic [IDX_WIDTH-1:0]    bit_idx;
  logic                    bound_exceeded;

  assign rem_shift      = {rem, value[bit_idx]};
  assign bound_exceeded = square > SQUARE_WIDTH'(value);

  always_comb begin
    if (rem_shift >= {1'b0, divisor}) begin
      rem_next = DIV_WIDTH'(rem_shift - {1'b0, divisor});
    end else begin
      rem_next = DIV_WIDTH'(rem_shift);
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (item_valid) begin
          state_next = (item.cls == CLS_TEST) ? ST_SQUARE : ST_DONE;
        end
      end
      ST_SQUARE: state_next = ST_BOUND;
      ST_BOUND:  state_next = bound_exceeded ? ST_DONE : ST_DIVIDE;
      ST_DIVIDE: begin
        if (bit_idx == '0) begin
          state_next = (rem_next == '0) ? ST_DONE : ST_SQUARE;
        end
      end
      ST_DONE: begin
        if (res.ready) begin
          state_next = ST_IDLE;
        end
      end
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    item_ready = 1'b0;
    res.valid  = 1'b0;
    unique case (state)
      ST_IDLE: item_ready = 1'b1;
      ST_DONE: res.valid = 1'b1;
      default: begin
        item_ready = 1'b0;
        res.valid  = 1'b0;
      end
    endcase
  end

  assign res.tested_value = value;
  assign res.is_prime     = prime;
  assign res.range_done   = last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      divisor <= FIRST_DIVISOR;
    end else begin
      state <= state_next;
      if (state == ST_IDLE) begin
        divisor <= FIRST_DIVISOR;
      end else if (state == ST_DIVIDE && bit_idx == '0 && rem_next != '0) begin
        divisor <= divisor + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (item_valid) begin
          value <= item.value;
          last  <= item.last;
          prime <= item.cls == CLS_PRIME;
        end
      end
      ST_SQUARE: square <= divisor * divisor;
      ST_BOUND: begin
        prime   <= 1'b1;
        rem     <= '0;
        bit_idx <= IDX_WIDTH'(VALUE_WIDTH - 1);
      end
      ST_DIVIDE: begin
        rem     <= rem_next;
        bit_idx <= bit_idx - 1'b1;
        if (bit_idx == '0 && rem_next == '0) begin
          prime <= 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

>>> hdl/trial_division_prime_test_top.sv
// Top level of the trial division prime test: front stage, queue and divider engine.
//
//   Channel  Dir  Fields                                 Handshake
//   req      in   candidate[31:0], last_in_range         valid/ready
//   res      out  tested_value[31:0], is_prime, range_done  valid/ready
//
// Zero, one, two, three and even candidates skip the divider loop and go straight to the result.
// An odd candidate n above three runs the SQUARE, BOUND and DIVIDE states for each divisor
// d tried with d*d <= n, DIVIDE forming the bit-serial remainder, and stops at the first exact divisor.
// Reset clears all control state; no clearing pass is needed.
// While a result waits on res.ready, the front stage and the queue keep taking up to three
// requests.
module trial_division_prime_test_top (
  input logic       clk,
  input logic       rst,
  tdp_req_if.sink   req,
  tdp_res_if.source res
);
  import tdp_pkg::*;

  item_t front_item;
  logic  front_valid;
  logic  front_ready;
  item_t queue_item;
  logic  queue_valid;
  logic  queue_ready;

  tdp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .item       (front_item),
    .item_valid (front_valid),
    .item_ready (front_ready)
  );

  tdp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_item  (front_item),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .pop_item   (queue_item),
    .pop_valid  (queue_valid),
    .pop_ready  (queue_ready)
  );

  tdp_back u_back (
    .clk        (clk),
    .rst        (rst),
    .item       (queue_item),
    .item_valid (queue_valid),
    .item_ready (queue_ready),
    .res        (res)
  );

endmodule

>>> hdl/tdp_checker.sv
// Port-level checker for the trial division prime test and its bind statement.
module tdp_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            res_valid,
  input logic                            res_ready,
  input logic [tdp_pkg::VALUE_WIDTH-1:0] res_tested_value,
  input logic                            res_is_prime,
  input logic                            res_range_done
);
  import tdp_pkg::*;

  a_no_result_after_reset: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("A result appeared right after reset.");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid)
    else $error("A stalled result was withdrawn.");

  a_payload_held: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> $stable(res_tested_value) && $stable(res_is_prime)
      && $stable(res_range_done))
    else $error("A stalled result changed.");

  a_prime_above_one: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_is_prime |-> res_tested_value > VALUE_WIDTH'(1))
    else $error("Zero or one was reported as prime.");

  a_even_prime_is_two: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_is_prime && !res_tested_value[0] |-> res_tested_value == VALUE_WIDTH'(2))
    else $error("An even number other than two was reported as prime.");

endmodule

bind trial_division_prime_test_top tdp_checker u_tdp_checker (
  .clk              (clk),
  .rst              (rst),
  .res_valid        (res.valid),
  .res_ready        (res.ready),
  .res_tested_value (res.tested_value),
  .res_is_prime     (res.is_prime),
  .res_range_done   (res.range_done)
);

>>> test/tb.sv
// Self-checking testbench for the trial division prime test with handshake pressure.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tdp_pkg::*;

  localparam int RANDOM_ITEMS = 82;
  localparam int BURST_ITEMS = 10;
  localparam int LONG_HOLD = 400;
  localparam int TAIL_CYCLES = 40;
  localparam int CYCLE_LIMIT = 5_000_000;
  localparam int PRINT_LIMIT = 60;
  localparam int N_DIRECTED = 18;

  typedef struct packed {
    logic [VALUE_WIDTH-1:0] value;
    logic                   prime;
    logic                   last;
  } verdict_t;

  typedef struct packed {
    logic [VALUE_WIDTH-1:0] value;
    logic                   last;
    logic                   known;
    logic                   want_prime;
  } stim_row_t;

  // Rows with known set carry an answer that is obvious by inspection.
  stim_row_t directed_rows [N_DIRECTED] = '{
    '{32'd0,          1'b0, 1'b1, 1'b0},
    '{32'd1,          1'b1, 1'b1, 1'b0},
    '{32'd2,          1'b0, 1'b1, 1'b1},
    '{32'd3,          1'b0, 1'b1, 1'b1},
    '{32'd4,          1'b0, 1'b1, 1'b0},
    '{32'd5,          1'b0, 1'b0, 1'b0},
    '{32'd9,          1'b0, 1'b0, 1'b0},
    '{32'd25,         1'b0, 1'b0, 1'b0},
    '{32'd49,         1'b1, 1'b0, 1'b0},
    '{32'd97,         1'b0, 1'b0, 1'b0},
    '{32'd121,        1'b0, 1'b0, 1'b0},
    '{32'd63001,      1'b0, 1'b0, 1'b0},
    '{32'd65521,      1'b0, 1'b0, 1'b0},
    '{32'd65537,      1'b1, 1'b0, 1'b0},
    '{32'h8000_0000,  1'b0, 1'b1, 1'b0},
    '{32'hFFFF_FFFE,  1'b0, 1'b1, 1'b0},
    '{32'h5555_5555,  1'b0, 1'b0, 1'b0},
    '{32'hFFFF_FFFF,  1'b1, 1'b1, 1'b0}
  };

  logic clk;
  logic rst;

  tdp_req_if req ();
  tdp_res_if res ();

  trial_division_prime_test_top dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .res (res)
  );

  verdict_t pending_verdicts [$];
  int       error_count = 0;
  int       cycle_count = 0;
  int       results_checked = 0;
  int       primes_seen = 0;
  int       requests_sent = 0;
  int       random_sent = 0;
  int       hold_asked = 0;

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  initial begin
    rst = 1'b1;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding.", cycle_count,
               pending_verdicts.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic bit prime_by_trial(input logic [VALUE_WIDTH-1:0] n);
    longint unsigned num;
    longint unsigned d;
    num = n;
    if (num <= 1) return 1'b0;
    for (d = 2; d <= num / d; d++) begin
      if (num % d == 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic int pick_gap(input bit quiet);
    if (quiet || $urandom_range(0, 2) == 0) return 0;
    if ($urandom_range(0, 9) == 0) return $urandom_range(12, 60);
    return $urandom_range(1, 3);
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    if (error_count < PRINT_LIMIT)
      $display("Mismatch at cycle %0d: %s got %0h, want %0h.", cycle_count, what, got, want);
    error_count++;
  endtask

  always @(posedge clk) begin
    verdict_t want;
    if (!rst && res.valid && res.ready) begin
      if (pending_verdicts.size() == 0) begin
        report_mismatch("unexpected result, value", res.tested_value, 0);
      end else begin
        want = pending_verdicts.pop_front();
        if (res.tested_value !== want.value)
          report_mismatch("tested_value", res.tested_value, want.value);
        if (res.is_prime !== want.prime)
          report_mismatch("is_prime", res.is_prime, want.prime);
        if (res.range_done !== want.last)
          report_mismatch("range_done", res.range_done, want.last);
        results_checked++;
        if (res.is_prime === 1'b1) primes_seen++;
      end
    end
  end

  initial begin : result_sink
    int stall_left;
    int hold_left;
    int hold_served;
    bit quiet;
    stall_left = 0;
    hold_left = 0;
    hold_served = 0;
    quiet = 1'b0;
    res.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (cycle_count % 128 == 0) quiet = ($urandom_range(0, 2) == 0);
      if (rst) begin
        res.ready <= 1'b0;
      end else if (hold_asked != hold_served) begin
        hold_served++;
        hold_left = LONG_HOLD;
        res.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        res.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        res.ready <= 1'b0;
      end else begin
        stall_left = pick_gap(quiet);
        res.ready <= (stall_left == 0);
      end
    end
  end

  task automatic offer_request(input logic [VALUE_WIDTH-1:0] value, input logic last,
                               input bit known, input bit want_prime, input int gap);
    verdict_t v;
    v.value = value;
    v.last = last;
    v.prime = known ? want_prime : prime_by_trial(value);
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.valid <= 1'b1;
    req.candidate <= value;
    req.last_in_range <= last;
    do @(posedge clk); while (req.ready !== 1'b1);
    pending_verdicts.insert(pending_verdicts.size(), v);
    requests_sent++;
  endtask

  task automatic wait_for_drain();
    req.valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
  endtask

  function automatic logic [VALUE_WIDTH-1:0] large_composite();
    longint unsigned factor;
    longint unsigned multiple;
    factor = 2 * $urandom_range(1, 49) + 1;
    multiple = $urandom_range(1, 32'hFFFF_FFFF / factor);
    return VALUE_WIDTH'(factor * multiple);
  endfunction

  initial begin : request_source
    bit                     quiet;
    int                     kind;
    int                     len;
    logic [VALUE_WIDTH-1:0] base;
    req.valid <= 1'b0;
    req.candidate <= '0;
    req.last_in_range <= 1'b0;
    quiet = 1'b0;
    do @(posedge clk); while (rst);

    foreach (directed_rows[i]) begin
      offer_request(directed_rows[i].value, directed_rows[i].last, directed_rows[i].known,
                    directed_rows[i].want_prime, pick_gap(quiet));
    end

    // Drain fully, then hold the result side while a burst of cheap requests backs up.
    wait_for_drain();
    hold_asked <= hold_asked + 1;
    for (int i = 0; i < BURST_ITEMS; i++) begin
      if (i % 2 == 0) base = $urandom & ~32'h1;
      else base = $urandom_range(0, 15);
      offer_request(base, 1'(i == BURST_ITEMS - 1), 1'b0, 1'b0, 0);
      random_sent++;
    end

    while (random_sent < RANDOM_ITEMS) begin
      if (random_sent % 16 == 0) quiet = ($urandom_range(0, 3) == 0);
      kind = $urandom_range(0, 9);
      if (kind < 5) begin
        len = $urandom_range(1, 8);
        if ($urandom_range(0, 3) == 0) base = $urandom_range(0, 40);
        else base = $urandom_range(0, 65535 - 8);
        for (int i = 0; i < len; i++) begin
          offer_request(base + i, 1'(i == len - 1), 1'b0, 1'b0, pick_gap(quiet));
          random_sent++;
        end
      end else if (kind < 7) begin
        offer_request(large_composite(), 1'($urandom), 1'b0, 1'b0, pick_gap(quiet));
        random_sent++;
      end else if (kind < 9) begin
        offer_request($urandom & ~32'h1, 1'($urandom), 1'b0, 1'b0, pick_gap(quiet));
        random_sent++;
      end else begin
        offer_request($urandom_range(0, 300), 1'($urandom), 1'b0, 1'b0, pick_gap(quiet));
        random_sent++;
      end
    end

    wait_for_drain();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Checked %0d results for %0d requests (%0d directed, %0d random), %0d primes.",
             results_checked, requests_sent, N_DIRECTED, random_sent, primes_seen);
    $display("Covered range sweeps with end markers, large composites and a %0d-cycle backlog.",
             LONG_HOLD);
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
